// ===== src/scrp_pkg.sv =====
// ----------------------------------------------------------------------------
// scrp_pkg
// Shared types, constants and elaboration-time tables for the shaded color
// ramp: per-entry ramp fraction, per-entry -log2 of that fraction, and the
// fractional exp2 root constants.
// ----------------------------------------------------------------------------
package scrp_pkg;

    localparam int RAMP_LEN   = 120;
    localparam int IDX_W      = 7;
    localparam int EXP_STAGES = 16;
    localparam int LOG_W      = 21;
    localparam int ACC_W      = 31;
    localparam int ROOT_W     = 30;
    localparam int BASE0      = 16;
    localparam int BASE1      = 136;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BANK      = 3'd0,
        CFG_AMBIENT   = 3'd1,
        CFG_DIFFUSE   = 3'd2,
        CFG_SPECULAR  = 3'd3,
        CFG_SHININESS = 3'd4,
        CFG_LIGHT     = 3'd5
    } cfg_reg_t;

    // Sideband that rides along the exp2 pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [15:0]      f16;
        logic             pw_one;
        logic             pw_zero;
        logic [4:0]       q;
    } exp_side_t;

    typedef logic [15:0]       f16_tab_t  [RAMP_LEN];
    typedef logic [LOG_W-1:0]  log_tab_t  [RAMP_LEN];
    typedef logic [ROOT_W-1:0] root_tab_t [EXP_STAGES];

    // Ramp fraction i/RAMP_LEN in Q0.16
    function automatic f16_tab_t build_f16_tab();
        f16_tab_t tab;
        for (int i = 0; i < RAMP_LEN; i++) begin
            tab[i] = 16'((longint'(i) << 16) / RAMP_LEN);
        end
        return tab;
    endfunction

    // -log2 of the ramp fraction in Q.16, by repeated squaring of the mantissa
    function automatic log_tab_t build_log_tab();
        log_tab_t        tab;
        longint unsigned f;
        longint unsigned m;
        longint unsigned sq;
        longint unsigned frac;
        int              p;
        for (int i = 0; i < RAMP_LEN; i++) begin
            f    = (longint'(i) << 16) / RAMP_LEN;
            frac = 0;
            p    = 0;
            for (int b = 0; b < 16; b++) begin
                if (f[b]) begin
                    p = b;
                end
            end
            m = f << (30 - p);
            for (int k = 0; k < 16; k++) begin
                sq   = (m * m) >> 30;
                frac = frac << 1;
                if (sq >= (64'd1 << 31)) begin
                    frac = frac | 64'd1;
                    m    = sq >> 1;
                end
                else begin
                    m = sq;
                end
            end
            if (f == 0) begin
                tab[i] = '0;
            end
            else begin
                tab[i] = LOG_W'((longint'(16 - p) << 16) - frac);
            end
        end
        return tab;
    endfunction

    // Integer square root, bit by bit
    function automatic longint unsigned isqrt64(longint unsigned n_in);
        longint unsigned n;
        longint unsigned res;
        longint unsigned bitv;
        n    = n_in;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > n) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q.30 for k = 1..16
    function automatic root_tab_t build_root_tab();
        root_tab_t       tab;
        longint unsigned root;
        root = 64'd1 << 29;
        for (int k = 0; k < EXP_STAGES; k++) begin
            root   = isqrt64(root << 30);
            tab[k] = ROOT_W'(root);
        end
        return tab;
    endfunction

    localparam f16_tab_t  F16_TAB  = build_f16_tab();
    localparam log_tab_t  LOG_TAB  = build_log_tab();
    localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

// ===== src/scrp_exp2.sv =====
// ----------------------------------------------------------------------------
// scrp_exp2
// Fractional exp2 pipeline: one stage per fraction bit, each stage scales the
// accumulator by 2^(-2^-k) when its bit of r is set.
// ----------------------------------------------------------------------------
module scrp_exp2 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [15:0]                  in_r,
    input  scrp_pkg::exp_side_t          in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [scrp_pkg::ACC_W-1:0]   out_acc,
    output scrp_pkg::exp_side_t          out_side
);
    import scrp_pkg::*;

    localparam logic [ACC_W-1:0] ONE_Q30 = ACC_W'(64'd1 << 30);

    logic             valid_reg [EXP_STAGES];
    logic [ACC_W-1:0] acc_reg   [EXP_STAGES];
    logic [15:0]      r_reg     [EXP_STAGES];
    exp_side_t        side_reg  [EXP_STAGES];

    logic             stage_ready [EXP_STAGES];
    logic             src_valid   [EXP_STAGES];
    logic [ACC_W-1:0] src_acc     [EXP_STAGES];
    logic [15:0]      src_r       [EXP_STAGES];
    exp_side_t        src_side    [EXP_STAGES];
    logic [ACC_W-1:0] acc_next    [EXP_STAGES];
    logic [ACC_W+ROOT_W-1:0] prod [EXP_STAGES];

    // Backpressure chain: a stage moves when it is empty or its successor moves
    always_comb
    begin
        for (int j = EXP_STAGES - 1; j >= 0; j--) begin
            if (j == EXP_STAGES - 1) begin
                stage_ready[j] = !valid_reg[j] || out_ready;
            end
            else begin
                stage_ready[j] = !valid_reg[j] || stage_ready[j+1];
            end
        end
    end

    // Stage sources and the conditional root multiply
    always_comb
    begin
        for (int j = 0; j < EXP_STAGES; j++) begin
            if (j == 0) begin
                src_valid[j] = in_valid;
                src_acc[j]   = ONE_Q30;
                src_r[j]     = in_r;
                src_side[j]  = in_side;
            end
            else begin
                src_valid[j] = valid_reg[j-1];
                src_acc[j]   = acc_reg[j-1];
                src_r[j]     = r_reg[j-1];
                src_side[j]  = side_reg[j-1];
            end
            prod[j] = src_acc[j] * ROOT_TAB[j];
            if (src_r[j][EXP_STAGES-1-j]) begin
                acc_next[j] = ACC_W'(prod[j] >> 30);
            end
            else begin
                acc_next[j] = src_acc[j];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int j = 0; j < EXP_STAGES; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end
        else begin
            for (int j = 0; j < EXP_STAGES; j++) begin
                if (stage_ready[j]) begin
                    valid_reg[j] <= src_valid[j];
                end
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < EXP_STAGES; j++) begin
            if (stage_ready[j] && src_valid[j]) begin
                acc_reg[j]  <= acc_next[j];
                r_reg[j]    <= src_r[j];
                side_reg[j] <= src_side[j];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[EXP_STAGES-1];
    assign out_acc   = acc_reg[EXP_STAGES-1];
    assign out_side  = side_reg[EXP_STAGES-1];

    // The root product never grows the accumulator past 1.0 nor below 0.25
    a_acc_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_acc <= ONE_Q30)
        else $error("exp2 accumulator above 1.0");
    a_acc_lower: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_acc >= (ONE_Q30 >> 2))
        else $error("exp2 accumulator below 0.25");
    a_acc_mid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[EXP_STAGES/2] |-> acc_reg[EXP_STAGES/2] <= ONE_Q30)
        else $error("exp2 accumulator above 1.0 mid pipe");

endmodule

// ===== src/shaded_color_ramp_entry.sv =====
// Throughput: one entry per cycle while the output is not stalled; the exp2
// root chain is 16 stages deep. Each stage has its own valid bit and moves
// when empty or drained, so bubbles close up under output stall.
// Reset: pipeline empties, registers take their reset values.
// ----------------------------------------------------------------------------
// shaded_color_ramp_entry
// Phong-style shaded palette entry: ambient + f*diffuse + f^s*specular,
// scaled by light, clamped and mapped to 0..255.
// ----------------------------------------------------------------------------
module shaded_color_ramp_entry (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [47:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [scrp_pkg::IDX_W-1:0]  entry_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  palette_address,
    output logic [7:0]                  red_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  blue_out
);
    import scrp_pkg::*;

    // Configuration registers
    logic        ramp_bank_reg;
    logic [47:0] ambient_reg;
    logic [47:0] diffuse_reg;
    logic [47:0] specular_reg;
    logic [15:0] shininess_reg;
    logic [47:0] light_reg;

    assign cfg_ready = 1'b1;

    // Write configuration on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ramp_bank_reg <= 1'b0;
            ambient_reg   <= '0;
            diffuse_reg   <= '0;
            specular_reg  <= '0;
            shininess_reg <= 16'h0E00;
            light_reg     <= '1;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BANK:      ramp_bank_reg <= cfg_data[0];
                CFG_AMBIENT:   ambient_reg   <= cfg_data;
                CFG_DIFFUSE:   diffuse_reg   <= cfg_data;
                CFG_SPECULAR:  specular_reg  <= cfg_data;
                CFG_SHININESS: shininess_reg <= cfg_data[15:0];
                CFG_LIGHT:     light_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Stage registers
    logic             a_valid_reg, b_valid_reg, p_valid_reg;
    logic             m_valid_reg, t_valid_reg, u_valid_reg, o_valid_reg;
    logic             a_ready, b_ready, p_ready, m_ready, t_ready, u_ready, o_ready;

    logic [IDX_W-1:0] a_idx_reg;
    logic [15:0]      a_f16_reg;
    logic [LOG_W-1:0] a_n_reg;
    logic             a_one_reg;
    logic             a_zero_reg;

    exp_side_t        b_side_reg;
    logic [15:0]      b_r_reg;

    logic [IDX_W-1:0] p_idx_reg;
    logic [15:0]      p_f16_reg;
    logic [16:0]      p_pw_reg;

    logic [IDX_W-1:0] m_idx_reg, t_idx_reg, u_idx_reg;
    logic [31:0]      m_d_reg [3];
    logic [32:0]      m_s_reg [3];
    logic [34:0]      t_reg   [3];
    logic [50:0]      u_reg   [3];

    logic [7:0]       o_addr_reg;
    logic [7:0]       o_col_reg [3];

    logic             x_valid;
    logic [ACC_W-1:0] x_acc;
    exp_side_t        x_side;

    // Backpressure chain
    assign o_ready  = !o_valid_reg || out_ready;
    assign u_ready  = !u_valid_reg || o_ready;
    assign t_ready  = !t_valid_reg || u_ready;
    assign m_ready  = !m_valid_reg || t_ready;
    assign p_ready  = !p_valid_reg || m_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    logic             b_in_ready;
    assign b_ready = !b_valid_reg || b_in_ready;

    // Stage A: clamp index, look up ramp fraction and its log
    logic [IDX_W-1:0] idx_c;
    always_comb
    begin
        if (entry_index >= IDX_W'(RAMP_LEN)) begin
            idx_c = IDX_W'(RAMP_LEN - 1);
        end
        else begin
            idx_c = entry_index;
        end
    end

    // Stage B: exponent times log
    logic [LOG_W+15:0] ns_prod;
    logic [28:0]       e_val;
    logic              e_big;
    exp_side_t         b_side_next;
    assign ns_prod = a_n_reg * shininess_reg;
    assign e_val   = ns_prod[LOG_W+15:8];
    assign e_big   = (|e_val[28:21]) || (e_val[20:16] > 5'd16);
    always_comb
    begin
        b_side_next.idx     = a_idx_reg;
        b_side_next.f16     = a_f16_reg;
        b_side_next.pw_one  = a_one_reg;
        b_side_next.pw_zero = a_zero_reg || e_big;
        b_side_next.q       = e_val[20:16];
    end

    scrp_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (b_in_ready),
        .in_r      (b_r_reg),
        .in_side   (b_side_reg),
        .out_valid (x_valid),
        .out_ready (p_ready),
        .out_acc   (x_acc),
        .out_side  (x_side)
    );

    // Stage P: integer part shift and special cases
    logic [5:0]  pw_shift;
    logic [16:0] pw_next;
    assign pw_shift = 6'd14 + {1'b0, x_side.q};
    always_comb
    begin
        if (x_side.pw_one) begin
            pw_next = 17'h10000;
        end
        else if (x_side.pw_zero) begin
            pw_next = '0;
        end
        else begin
            pw_next = 17'(x_acc >> pw_shift);
        end
    end

    // Stages M, T, U, O per channel
    logic [15:0] amb_c [3];
    logic [15:0] dif_c [3];
    logic [15:0] spe_c [3];
    logic [15:0] lit_c [3];
    logic [31:0] md_next [3];
    logic [32:0] ms_next [3];
    logic [34:0] t_next  [3];
    logic [50:0] u_next  [3];
    logic [55:0] scaled  [3];
    logic [7:0]  col_next [3];
    always_comb
    begin
        for (int c = 0; c < 3; c++) begin
            amb_c[c]   = ambient_reg[47-16*c -: 16];
            dif_c[c]   = diffuse_reg[47-16*c -: 16];
            spe_c[c]   = specular_reg[47-16*c -: 16];
            lit_c[c]   = light_reg[47-16*c -: 16];
            md_next[c] = p_f16_reg * dif_c[c];
            ms_next[c] = p_pw_reg * spe_c[c];
            t_next[c]  = {3'b000, amb_c[c], 16'h0000} + 35'(m_d_reg[c]) + 35'(m_s_reg[c]);
            u_next[c]  = t_reg[c] * lit_c[c];
            scaled[c]  = (56'(u_reg[c]) << 8) - 56'(u_reg[c]);
            if (|u_reg[c][50:48]) begin
                col_next[c] = 8'hFF;
            end
            else begin
                col_next[c] = scaled[c][55:48];
            end
        end
    end

    logic [7:0] base_addr;
    assign base_addr = ramp_bank_reg ? 8'(BASE1) : 8'(BASE0);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (p_ready) p_valid_reg <= x_valid;
            if (m_ready) m_valid_reg <= p_valid_reg;
            if (t_ready) t_valid_reg <= m_valid_reg;
            if (u_ready) u_valid_reg <= t_valid_reg;
            if (o_ready) o_valid_reg <= u_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid) begin
            a_idx_reg  <= idx_c;
            a_f16_reg  <= F16_TAB[idx_c];
            a_n_reg    <= LOG_TAB[idx_c];
            a_one_reg  <= (shininess_reg == 16'h0000);
            a_zero_reg <= (F16_TAB[idx_c] == 16'h0000);
        end
        if (b_ready && a_valid_reg) begin
            b_side_reg <= b_side_next;
            b_r_reg    <= e_val[15:0];
        end
        if (p_ready && x_valid) begin
            p_idx_reg <= x_side.idx;
            p_f16_reg <= x_side.f16;
            p_pw_reg  <= pw_next;
        end
        if (m_ready && p_valid_reg) begin
            m_idx_reg <= p_idx_reg;
            m_d_reg   <= md_next;
            m_s_reg   <= ms_next;
        end
        if (t_ready && m_valid_reg) begin
            t_idx_reg <= m_idx_reg;
            t_reg     <= t_next;
        end
        if (u_ready && t_valid_reg) begin
            u_idx_reg <= t_idx_reg;
            u_reg     <= u_next;
        end
        if (o_ready && u_valid_reg) begin
            o_addr_reg <= base_addr + 8'(u_idx_reg);
            o_col_reg  <= col_next;
        end
    end

    assign out_valid       = o_valid_reg;
    assign palette_address = o_addr_reg;
    assign red_out         = o_col_reg[0];
    assign green_out       = o_col_reg[1];
    assign blue_out        = o_col_reg[2];

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> palette_address >= 8'(BASE0))
        else $error("palette address below first bank");
    a_pw_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> p_pw_reg <= 17'h10000)
        else $error("power term above 1.0");
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (u_valid_reg && o_ready && (|u_reg[0][50:48])) |=> red_out == 8'hFF)
        else $error("red overflow not clamped");

endmodule
